// ===== src/mmt_pkg.sv =====
// Shared widths and helpers for the multiset mode tracker.
package mmt_pkg;

  localparam int VALUE_W = 10;
  localparam int COUNT_W = 10;

  // Address width of a RAM of the given depth, never below one bit.
  function automatic int addr_w(input longint depth);
    addr_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== src/mmt_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module mmt_ram
  import mmt_pkg::*;
#(
  parameter int     WIDTH = 8,
  parameter longint DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/multiset_mode_tracker.sv =====
// Multiset mode tracker: per-value counts, per-block count histograms and block maxima.
//
// Requests (kind, value) enter on req_valid/req_ready; kind 0 adds one occurrence of
// value, kind 1 removes one. Every request yields exactly one response on
// rsp_valid/rsp_ready: the smallest value holding the greatest count, that count, and
// error when the request was dropped (remove of an absent value, add at the count
// limit, value out of range). An empty multiset reports value 0, count 0.
// One request is worked at a time, through S_DIV1, S_DIV2, S_RD, S_CHK, S_H1 and S_H2,
// then S_H3 for a remove only, then the block walk in S_QA and the value scan in S_QC;
// an empty set skips the value scan and a dropped request skips the histogram update.
// A new request is accepted once the machine is back in S_IDLE. The order of steps
// follows from the single read port of each state RAM: the update is a read-modify-write
// of the count and histogram RAMs, and the query walks the block maxima RAM and then
// the count RAM of the winning block, one entry per cycle.
// The response sits in an output register; the next request is taken while it waits,
// but its own response is held back until the receiver takes the earlier one.
// After reset a clearing pass zeroes all RAMs, one entry per cycle, over
// max(NUM_BLOCKS * (MAX_COUNT + 1), NUM_VALUES) addresses (32768 at the defaults);
// req_ready stays low until it ends.
module multiset_mode_tracker
  import mmt_pkg::*;
#(
  parameter int NUM_VALUES = 1024,
  parameter int BLOCK_SIZE = 32,
  parameter int MAX_COUNT  = 1023
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               kind,
  input  logic [VALUE_W-1:0] value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [VALUE_W-1:0] mode_value,
  output logic [COUNT_W-1:0] mode_count,
  output logic               error
);

  localparam int     NUM_BLOCKS = (NUM_VALUES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam longint HIST_ROW   = longint'(MAX_COUNT) + 1;
  localparam longint HIST_DEPTH = longint'(NUM_BLOCKS) * HIST_ROW;
  localparam longint CLR_LEN    = (HIST_DEPTH > NUM_VALUES) ? HIST_DEPTH
                                                            : longint'(NUM_VALUES);
  localparam int VW   = addr_w(NUM_VALUES);
  localparam int BKW  = addr_w(NUM_BLOCKS);
  localparam int HAW  = addr_w(HIST_DEPTH);
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int HW   = $clog2(BLOCK_SIZE + 1);
  localparam int CLW  = $clog2(CLR_LEN + 1);
  localparam int QW   = $clog2(((NUM_BLOCKS > BLOCK_SIZE) ? NUM_BLOCKS : BLOCK_SIZE) + 1);
  localparam int PVW  = $clog2(NUM_BLOCKS * BLOCK_SIZE + 1);
  localparam int BSW  = $clog2(BLOCK_SIZE + 1);
  localparam int DW   = ((VW > BSW) ? VW : BSW) + 1;
  localparam int MW   = 2 * VW + 1;
  localparam int RECIP = (2 ** VW) / BLOCK_SIZE;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV1 = 4'd1;
  localparam logic [3:0] S_DIV2 = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_H1   = 4'd5;
  localparam logic [3:0] S_H2   = 4'd6;
  localparam logic [3:0] S_H3   = 4'd7;
  localparam logic [3:0] S_QA   = 4'd8;
  localparam logic [3:0] S_QC   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic KIND_ADD = 1'b0;

  logic [3:0]     state;
  logic [CLW-1:0] clr_cnt;
  logic           clearing;
  logic           op_kind;
  logic [VW-1:0]  idx;
  logic           err;
  logic [BKW-1:0] q0;
  logic [BKW-1:0] blk;
  logic [HAW-1:0] row_base;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_new;
  logic [CW-1:0]  bmax;
  logic [CW-1:0]  top;
  logic [BKW-1:0] top_blk;
  logic [QW-1:0]  qcnt;
  logic [PVW-1:0] base;
  logic [VALUE_W-1:0] res_value;
  logic [COUNT_W-1:0] res_count;

  // RAM ports
  logic           vc_we;
  logic [VW-1:0]  vc_waddr, vc_raddr;
  logic [CW-1:0]  vc_wdata, vc_rdata;
  logic           hs_we;
  logic [HAW-1:0] hs_waddr, hs_raddr;
  logic [HW-1:0]  hs_wdata, hs_rdata;
  logic           bm_we;
  logic [BKW-1:0] bm_waddr, bm_raddr;
  logic [CW-1:0]  bm_wdata, bm_rdata;

  // Combinational helpers
  logic           in_range;
  logic [MW-1:0]  prod;
  logic [DW-1:0]  rem;
  logic           err_now;
  logic [CW-1:0]  cnt_c_new;
  logic [CW-1:0]  fin_top;
  logic [BKW-1:0] fin_blk;
  logic [PVW-1:0] cur;
  logic           hit;
  logic           stop;
  logic           out_free;

  assign clearing  = (clr_cnt != CLW'(CLR_LEN));
  assign req_ready = (state == S_IDLE) && !clearing;
  assign out_free  = !rsp_valid || rsp_ready;

  assign in_range  = 32'(value) < 32'(NUM_VALUES);
  assign prod      = MW'(idx) * MW'(RECIP);
  assign rem       = DW'(idx) - DW'(q0) * DW'(BLOCK_SIZE);
  assign err_now   = (op_kind == KIND_ADD) ? (vc_rdata == CW'(MAX_COUNT))
                                           : (vc_rdata == '0);
  assign cnt_c_new = (op_kind == KIND_ADD) ? vc_rdata + CW'(1) : vc_rdata - CW'(1);

  // Running block maximum; first block to reach the maximum wins (strict compare).
  always_comb begin
    fin_top = top;
    fin_blk = top_blk;
    if (qcnt != '0 && bm_rdata > top) begin
      fin_top = bm_rdata;
      fin_blk = BKW'(qcnt - QW'(1));
    end
  end

  assign cur  = base + PVW'(qcnt);
  assign hit  = (qcnt != '0) && (vc_rdata == top);
  assign stop = (qcnt == QW'(BLOCK_SIZE)) || (cur >= PVW'(NUM_VALUES));

  always_comb begin
    vc_we    = 1'b0;
    vc_waddr = idx;
    vc_wdata = cnt_c_new;
    vc_raddr = idx;
    hs_we    = 1'b0;
    hs_waddr = row_base + HAW'(cnt);
    hs_wdata = hs_rdata - HW'(1);
    hs_raddr = row_base + HAW'(vc_rdata);
    bm_we    = 1'b0;
    bm_waddr = blk;
    bm_wdata = cnt_new;
    bm_raddr = blk;
    if (clearing) begin
      vc_we    = longint'(clr_cnt) < longint'(NUM_VALUES);
      vc_waddr = VW'(clr_cnt);
      vc_wdata = '0;
      hs_we    = longint'(clr_cnt) < HIST_DEPTH;
      hs_waddr = HAW'(clr_cnt);
      hs_wdata = '0;
      bm_we    = longint'(clr_cnt) < longint'(NUM_BLOCKS);
      bm_waddr = BKW'(clr_cnt);
      bm_wdata = '0;
    end else begin
      case (state)
        S_CHK: begin
          vc_we = !err_now;
        end
        S_H1: begin
          hs_we    = (cnt != '0);
          hs_raddr = row_base + HAW'(cnt_new);
        end
        S_H2: begin
          hs_we    = (cnt_new != '0);
          hs_waddr = row_base + HAW'(cnt_new);
          hs_wdata = hs_rdata + HW'(1);
          hs_raddr = row_base + HAW'(bmax);
          bm_we    = (op_kind == KIND_ADD) && (cnt_new > bmax);
        end
        S_H3: begin
          // block max drops when its last holder is gone
          bm_we    = (bmax != '0) && (hs_rdata == '0);
          bm_wdata = bmax - CW'(1);
        end
        S_QA: begin
          bm_raddr = BKW'(qcnt);
        end
        S_QC: begin
          vc_raddr = VW'(cur);
        end
        default: begin
        end
      endcase
    end
  end

  mmt_ram #(.WIDTH(CW), .DEPTH(NUM_VALUES)) u_value_count (
    .clk, .we(vc_we), .waddr(vc_waddr), .wdata(vc_wdata),
    .raddr(vc_raddr), .rdata(vc_rdata)
  );

  mmt_ram #(.WIDTH(HW), .DEPTH(HIST_DEPTH)) u_hist (
    .clk, .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .raddr(hs_raddr), .rdata(hs_rdata)
  );

  mmt_ram #(.WIDTH(CW), .DEPTH(NUM_BLOCKS)) u_block_max (
    .clk, .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + CLW'(1);
      end
      // S_OUT loads the next response itself
      if (rsp_valid && rsp_ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            op_kind <= kind;
            idx     <= VW'(value);
            err     <= !in_range;
            top     <= '0;
            top_blk <= '0;
            qcnt    <= '0;
            state   <= in_range ? S_DIV1 : S_QA;
          end
        end
        S_DIV1: begin
          q0    <= BKW'(prod >> VW);
          state <= S_DIV2;
        end
        S_DIV2: begin
          // reciprocal estimate is at most one low
          blk   <= (rem >= DW'(BLOCK_SIZE)) ? q0 + BKW'(1) : q0;
          state <= S_RD;
        end
        S_RD: begin
          row_base <= HAW'(blk) * HAW'(HIST_ROW);
          state    <= S_CHK;
        end
        S_CHK: begin
          cnt     <= vc_rdata;
          cnt_new <= cnt_c_new;
          bmax    <= bm_rdata;
          err     <= err_now;
          state   <= err_now ? S_QA : S_H1;
        end
        S_H1: begin
          state <= S_H2;
        end
        S_H2: begin
          state <= (op_kind == KIND_ADD) ? S_QA : S_H3;
        end
        S_H3: begin
          state <= S_QA;
        end
        S_QA: begin
          top     <= fin_top;
          top_blk <= fin_blk;
          if (qcnt == QW'(NUM_BLOCKS)) begin
            qcnt <= '0;
            if (fin_top == '0) begin
              res_value <= '0;
              res_count <= '0;
              state     <= S_OUT;
            end else begin
              base  <= PVW'(fin_blk) * PVW'(BLOCK_SIZE);
              state <= S_QC;
            end
          end else begin
            qcnt <= qcnt + QW'(1);
          end
        end
        S_QC: begin
          if (hit) begin
            res_value <= VALUE_W'(cur - PVW'(1));
            res_count <= COUNT_W'(top);
            state     <= S_OUT;
          end else if (stop) begin
            res_value <= '0;
            res_count <= '0;
            state     <= S_OUT;
          end else begin
            qcnt <= qcnt + QW'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            mode_value <= res_value;
            mode_count <= res_count;
            error      <= err;
            rsp_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
